// ===== design/kvd_pkg.sv =====
// Shared definitions for the key/value deframer: parse phase codes, verdict codes,
// register map constants and the result item type. No dependencies.
package kvd_pkg;

	// Parse phases.
	localparam logic [2:0] PH_CNT_HI  = 3'd0;
	localparam logic [2:0] PH_CNT_LO  = 3'd1;
	localparam logic [2:0] PH_KLEN_HI = 3'd2;
	localparam logic [2:0] PH_KLEN_LO = 3'd3;
	localparam logic [2:0] PH_VLEN_HI = 3'd4;
	localparam logic [2:0] PH_VLEN_LO = 3'd5;
	localparam logic [2:0] PH_KEY     = 3'd6;
	localparam logic [2:0] PH_VAL     = 3'd7;

	// Verdict codes.
	localparam logic [1:0] VERDICT_NONE   = 2'd0;
	localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
	localparam logic [1:0] VERDICT_REJECT = 2'd2;

	// Register map.
	localparam int unsigned ADDR_W = 3;
	localparam logic REG_MAX_PAIRS     = 1'b0;
	localparam logic REG_STR_LEN_LIMIT = 1'b1;
	localparam logic [15:0] MAX_PAIRS_RESET     = 16'd64;
	localparam logic [15:0] STR_LEN_LIMIT_RESET = 16'd255;

	typedef struct packed {
		logic        has_byte;
		logic [7:0]  content_byte;
		logic        is_value;
		logic        string_end;
		logic [15:0] pair_number;
		logic [1:0]  verdict;
	} result_t;

endpackage

// ===== design/kv_length_prefixed_deframer.sv =====
// Top level of the length-prefixed key/value deframer: input register, parser,
// result buffer and APB limit registers. Depends on kvd_pkg and the kvd_* modules.

// The deframer takes one message byte per item on the slave stream (s_tlast marks
// the final byte of a message) and sustains one item per clock cycle while the
// output buffer has room. Each item is captured in an input register and parsed
// from it by a single pass of short logic against the parse state; a result item
// (a key or value byte, a verdict, or both) then enters a two-entry output buffer.
// The input stalls only when both output buffer entries are occupied and the
// parsed byte produces a result. Header bytes and trailing bytes produce no
// result item unless they are the final byte, which always carries a verdict.
// Key and value bytes are streamed before the verdict of their message is known:
// a consumer must drop the bytes of a message whose final item carries the reject
// verdict. The limits max_pairs and str_len_limit are written over APB at
// addresses 0 and 4 and must only be changed while the block is idle.
module kv_length_prefixed_deframer (
	input  logic                       clk,
	input  logic                       arst_n,
	// Slave stream.
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [7:0] data_byte
	input  logic                       s_tlast,   // final_byte
	// Master stream.
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [31:0]                m_tdata,   // [7:0] content_byte, [23:8] pair_number,
	                                              // [25:24] verdict, [31:26] zero
	output logic [1:0]                 m_tuser,   // [0] has_byte, [1] is_value
	output logic                       m_tlast,   // string_end
	// APB configuration port.
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [kvd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import kvd_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        final_s1;
	logic        advance;
	logic        res_valid;
	logic        buf_full;
	result_t     res;
	result_t     out_res;
	logic [15:0] max_pairs;
	logic [15:0] str_len_limit;

	kvd_cfg_regs u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.max_pairs     (max_pairs),
		.str_len_limit (str_len_limit)
	);

	// The item in the input register is parsed when its result (if any) has room.
	assign advance  = valid_s1 & (~res_valid | ~buf_full);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			final_s1 <= s_tlast;
		end
	end

	kvd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.data_byte     (byte_s1),
		.final_byte    (final_s1),
		.max_pairs     (max_pairs),
		.str_len_limit (str_len_limit),
		.res_valid     (res_valid),
		.res           (res)
	);

	kvd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance & res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {6'd0, out_res.verdict, out_res.pair_number, out_res.content_byte};
	assign m_tuser = {out_res.is_value, out_res.has_byte};
	assign m_tlast = out_res.string_end;

	// A parsed item that yields a result never goes to a full buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_valid |-> !buf_full)
		else $error("result pushed into full output buffer");

	// A result item without a byte carries only a verdict.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[25:24] != VERDICT_NONE && !m_tlast
			&& !m_tuser[1] && m_tdata[23:0] == 24'd0)
		else $error("byte-less result item without verdict or with stray fields");

	// The verdict code never takes the unused value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[25:24] != 2'd3)
		else $error("invalid verdict code on output");

	// An input item held in the register is not lost while the parser waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(final_s1))
		else $error("stalled input register changed");

endmodule

// ===== design/kvd_cfg_regs.sv =====
// APB register file for the deframer limits (max_pairs, str_len_limit).
// Depends on kvd_pkg.
module kvd_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [kvd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output logic [15:0]                max_pairs,
	output logic [15:0]                str_len_limit
);
	import kvd_pkg::*;

	logic [15:0] max_pairs_q;
	logic [15:0] str_len_limit_q;
	logic        wr_en;
	logic        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pairs_q     <= MAX_PAIRS_RESET;
			str_len_limit_q <= STR_LEN_LIMIT_RESET;
		end else if (wr_en) begin
			if (reg_sel == REG_MAX_PAIRS) begin
				max_pairs_q <= pwdata[15:0];
			end else begin
				str_len_limit_q <= pwdata[15:0];
			end
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (reg_sel == REG_MAX_PAIRS) begin
			prdata[15:0] = max_pairs_q;
		end else begin
			prdata[15:0] = str_len_limit_q;
		end
	end

	assign max_pairs     = max_pairs_q;
	assign str_len_limit = str_len_limit_q;

endmodule

// ===== design/kvd_parser.sv =====
// Parse state and next-state logic: consumes one registered byte per step and
// forms the result item for it. Depends on kvd_pkg.
module kvd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       data_byte,
	input  logic             final_byte,
	input  logic [15:0]      max_pairs,
	input  logic [15:0]      str_len_limit,
	output logic             res_valid,
	output kvd_pkg::result_t res
);
	import kvd_pkg::*;

	logic [2:0]  phase_q, phase_n;
	logic [7:0]  header_shift_q, header_shift_n;
	logic [15:0] pairs_left_q, pairs_left_n;
	logic [15:0] pair_index_q, pair_index_n;
	logic [15:0] key_length_q, key_length_n;
	logic [15:0] value_length_q, value_length_n;
	logic [15:0] bytes_left_q, bytes_left_n;
	logic        rejected_q, rejected_n;
	logic [15:0] joined;
	logic [15:0] bytes_dec;

	assign joined    = {header_shift_q, data_byte};
	assign bytes_dec = bytes_left_q - 16'd1;

	always_comb begin
		phase_n        = phase_q;
		header_shift_n = header_shift_q;
		pairs_left_n   = pairs_left_q;
		pair_index_n   = pair_index_q;
		key_length_n   = key_length_q;
		value_length_n = value_length_q;
		bytes_left_n   = bytes_left_q;
		rejected_n     = rejected_q;
		res            = '0;

		if (!rejected_q) begin
			case (phase_q)
				PH_CNT_HI: begin
					header_shift_n = data_byte;
					phase_n        = PH_CNT_LO;
				end
				PH_CNT_LO: begin
					pairs_left_n = joined;
					pair_index_n = 16'd0;
					rejected_n   = joined > max_pairs;
					phase_n      = PH_KLEN_HI;
				end
				PH_KLEN_HI: begin
					// With no pairs left every byte is trailing and ignored.
					if (pairs_left_q != 16'd0) begin
						header_shift_n = data_byte;
						phase_n        = PH_KLEN_LO;
					end
				end
				PH_KLEN_LO: begin
					key_length_n = joined;
					phase_n      = PH_VLEN_HI;
				end
				PH_VLEN_HI: begin
					header_shift_n = data_byte;
					phase_n        = PH_VLEN_LO;
				end
				PH_VLEN_LO: begin
					value_length_n = joined;
					if (key_length_q > str_len_limit || joined > str_len_limit) begin
						rejected_n = 1'b1;
					end else if (key_length_q != 16'd0) begin
						bytes_left_n = key_length_q;
						phase_n      = PH_KEY;
					end else if (joined != 16'd0) begin
						bytes_left_n = joined;
						phase_n      = PH_VAL;
					end else begin
						// Empty key and empty value: the pair is complete here.
						pairs_left_n = pairs_left_q - 16'd1;
						pair_index_n = pair_index_q + 16'd1;
						phase_n      = PH_KLEN_HI;
					end
				end
				PH_KEY: begin
					res.has_byte     = 1'b1;
					res.content_byte = data_byte;
					res.pair_number  = pair_index_q;
					bytes_left_n     = bytes_dec;
					if (bytes_dec == 16'd0) begin
						res.string_end = 1'b1;
						if (value_length_q != 16'd0) begin
							bytes_left_n = value_length_q;
							phase_n      = PH_VAL;
						end else begin
							pairs_left_n = pairs_left_q - 16'd1;
							pair_index_n = pair_index_q + 16'd1;
							phase_n      = PH_KLEN_HI;
						end
					end
				end
				PH_VAL: begin
					res.has_byte     = 1'b1;
					res.content_byte = data_byte;
					res.is_value     = 1'b1;
					res.pair_number  = pair_index_q;
					bytes_left_n     = bytes_dec;
					if (bytes_dec == 16'd0) begin
						res.string_end = 1'b1;
						pairs_left_n   = pairs_left_q - 16'd1;
						pair_index_n   = pair_index_q + 16'd1;
						phase_n        = PH_KLEN_HI;
					end
				end
				default: begin
					phase_n = PH_CNT_HI;
				end
			endcase
		end

		if (final_byte) begin
			res.verdict = (!rejected_n && phase_n == PH_KLEN_HI && pairs_left_n == 16'd0)
				? VERDICT_ACCEPT : VERDICT_REJECT;
			phase_n        = PH_CNT_HI;
			header_shift_n = 8'd0;
			pairs_left_n   = 16'd0;
			pair_index_n   = 16'd0;
			key_length_n   = 16'd0;
			value_length_n = 16'd0;
			bytes_left_n   = 16'd0;
			rejected_n     = 1'b0;
		end
	end

	assign res_valid = res.has_byte | final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_CNT_HI;
			header_shift_q <= 8'd0;
			pairs_left_q   <= 16'd0;
			pair_index_q   <= 16'd0;
			key_length_q   <= 16'd0;
			value_length_q <= 16'd0;
			bytes_left_q   <= 16'd0;
			rejected_q     <= 1'b0;
		end else if (step) begin
			phase_q        <= phase_n;
			header_shift_q <= header_shift_n;
			pairs_left_q   <= pairs_left_n;
			pair_index_q   <= pair_index_n;
			key_length_q   <= key_length_n;
			value_length_q <= value_length_n;
			bytes_left_q   <= bytes_left_n;
			rejected_q     <= rejected_n;
		end
	end

endmodule

// ===== design/kvd_out_buf.sv =====
// Two-entry result buffer: holds finished result items so the parser keeps
// accepting while the downstream side stalls, until both entries are occupied. Depends on kvd_pkg.
module kvd_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  kvd_pkg::result_t push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_ready,
	output kvd_pkg::result_t out_data
);
	import kvd_pkg::*;

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full      = count_q == 2'd2;
	assign out_valid = count_q != 2'd0;
	assign pop       = out_valid & out_ready;
	assign out_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
